// ----- hdl/lbte_pkg.sv -----
`default_nettype none
package lbte_pkg;

  // Saturation limits and fixed divisors of the timing code
  localparam logic [15:0] ON_MAX_MS    = 16'd4700;
  localparam logic [15:0] OFF_MAX_MS   = 16'd4800;
  localparam logic [12:0] RAMP_MAX_MS  = 13'd1550;
  localparam logic [17:0] RAMP_DIV     = 18'd10323;
  localparam logic [17:0] STEADY_DIV   = 18'd1066;
  localparam logic [17:0] OFF_DIV      = 18'd320;
  localparam logic [17:0] RAMP_SCALE   = 18'd100;
  localparam logic [17:0] STEADY_SCALE = 18'd10;
  localparam logic [7:0]  PCT_FULL     = 8'd100;
  localparam logic [6:0]  PCT_DEFAULT  = 7'd45;
  localparam logic [3:0]  COUNT_MAX    = 4'hF;

  // Reciprocal of 100: ceil(2^26 / 100), exact for any 19-bit dividend
  localparam int unsigned    RECIP_SHIFT = 26;
  localparam logic [19:0]    RECIP_100   = 20'd671089;

  localparam int unsigned MS_W   = 13;  // saturated millisecond values
  localparam int unsigned PROD_W = 19;  // percent times milliseconds

  typedef struct packed {
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [6:0]  rise_pct;
    logic [6:0]  fall_pct;
  } req_t;

  typedef struct packed {
    logic [7:0] slew_byte;
    logic [7:0] pulse_byte;
  } rsp_t;

  // Per-item flags carried down the pipeline
  typedef struct packed {
    logic rise_req;
    logic fall_req;
    logic steady_req;
    logic both_zero;
  } flags_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod_rise;
    logic [PROD_W-1:0] prod_fall;
    logic [PROD_W-1:0] prod_on;
    logic [MS_W-1:0]   off_ms;
    flags_t            flags;
  } prod_t;

  typedef struct packed {
    logic [MS_W-1:0] t_rise;
    logic [MS_W-1:0] t_fall;
    logic [MS_W-1:0] t_on;
    logic [MS_W-1:0] off_ms;
    flags_t          flags;
  } time_t;

  // Count how many multiples of step x reaches, capped at COUNT_MAX
  function automatic logic [3:0] count_steps(input logic [17:0] x, input logic [17:0] step);
    logic [3:0] n;
    n = '0;
    for (int k = 1; k <= int'(COUNT_MAX); k++) begin
      if (x >= 18'(k) * step) begin
        n = 4'(k);
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/lbte_sat.sv -----
`default_nettype none
module lbte_sat (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          valid_in,
  input  wire lbte_pkg::req_t req,
  output logic               valid,
  output lbte_pkg::prod_t    prod
);
  import lbte_pkg::*;

  logic [MS_W-1:0] on_sat;
  logic [MS_W-1:0] off_sat;
  logic [7:0]      pct_sum;
  logic [6:0]      up;
  logic [6:0]      down;
  logic [6:0]      steady_pct;
  prod_t           prod_next;

  // Saturate times and fix an oversized percent pair
  always_comb begin
    on_sat     = (req.on_ms > ON_MAX_MS) ? MS_W'(ON_MAX_MS) : req.on_ms[MS_W-1:0];
    off_sat    = (req.off_ms > OFF_MAX_MS) ? MS_W'(OFF_MAX_MS) : req.off_ms[MS_W-1:0];
    pct_sum    = {1'b0, req.rise_pct} + {1'b0, req.fall_pct};
    up         = (pct_sum > PCT_FULL) ? PCT_DEFAULT : req.rise_pct;
    down       = (pct_sum > PCT_FULL) ? PCT_DEFAULT : req.fall_pct;
    steady_pct = 7'(PCT_FULL - {1'b0, up} - {1'b0, down});

    prod_next.prod_rise        = PROD_W'(up) * PROD_W'(on_sat);
    prod_next.prod_fall        = PROD_W'(down) * PROD_W'(on_sat);
    prod_next.prod_on          = PROD_W'(steady_pct) * PROD_W'(on_sat);
    prod_next.off_ms           = off_sat;
    prod_next.flags.rise_req   = (up != '0);
    prod_next.flags.fall_req   = (down != '0);
    prod_next.flags.steady_req = (steady_pct != '0);
    prod_next.flags.both_zero  = (req.on_ms == '0) && (req.off_ms == '0);
  end

  // Advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= prod_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lbte_div.sv -----
`default_nettype none
module lbte_div (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           valid_in,
  input  wire lbte_pkg::prod_t prod,
  output logic                valid,
  output lbte_pkg::time_t     tm
);
  import lbte_pkg::*;

  localparam int unsigned MUL_W = PROD_W + 20;

  logic [MUL_W-1:0] mul_rise;
  logic [MUL_W-1:0] mul_fall;
  logic [MUL_W-1:0] mul_on;
  time_t            tm_next;

  // Divide each product by 100 through the reciprocal
  always_comb begin
    mul_rise = MUL_W'(prod.prod_rise) * MUL_W'(RECIP_100);
    mul_fall = MUL_W'(prod.prod_fall) * MUL_W'(RECIP_100);
    mul_on   = MUL_W'(prod.prod_on) * MUL_W'(RECIP_100);

    tm_next.t_rise = mul_rise[RECIP_SHIFT +: MS_W];
    tm_next.t_fall = mul_fall[RECIP_SHIFT +: MS_W];
    tm_next.t_on   = mul_on[RECIP_SHIFT +: MS_W];
    tm_next.off_ms = prod.off_ms;
    tm_next.flags  = prod.flags;
  end

  // Advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm <= tm_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lbte_split.sv -----
`default_nettype none
module lbte_split (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           valid_in,
  input  wire lbte_pkg::time_t tm_in,
  output logic                valid,
  output lbte_pkg::time_t     tm
);
  import lbte_pkg::*;

  logic [MS_W-1:0] rise_excess;
  logic [MS_W-1:0] fall_excess;
  time_t           tm_next;

  // Cap both ramps and move the excess into the steady part
  always_comb begin
    rise_excess = (tm_in.t_rise > RAMP_MAX_MS) ? tm_in.t_rise - RAMP_MAX_MS : '0;
    fall_excess = (tm_in.t_fall > RAMP_MAX_MS) ? tm_in.t_fall - RAMP_MAX_MS : '0;

    tm_next        = tm_in;
    tm_next.t_rise = tm_in.t_rise - rise_excess;
    tm_next.t_fall = tm_in.t_fall - fall_excess;
    tm_next.t_on   = tm_in.t_on + rise_excess + fall_excess;
  end

  // Advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm <= tm_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/lbte_count.sv -----
`default_nettype none
module lbte_count (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           valid_in,
  input  wire lbte_pkg::time_t tm,
  output logic                valid,
  output lbte_pkg::rsp_t      rsp
);
  import lbte_pkg::*;

  logic [3:0] n_rise;
  logic [3:0] n_fall;
  logic [3:0] n_on;
  logic [3:0] n_off;
  rsp_t       rsp_next;

  // Scale to 4-bit counts, forcing 1 if requested; all 0 if no times
  always_comb begin
    n_rise = count_steps(18'(tm.t_rise) * RAMP_SCALE, RAMP_DIV);
    n_fall = count_steps(18'(tm.t_fall) * RAMP_SCALE, RAMP_DIV);
    n_on   = count_steps(18'(tm.t_on) * STEADY_SCALE, STEADY_DIV);
    n_off  = count_steps(18'(tm.off_ms), OFF_DIV);

    if (n_rise == '0 && tm.flags.rise_req) begin
      n_rise = 4'd1;
    end
    if (n_fall == '0 && tm.flags.fall_req) begin
      n_fall = 4'd1;
    end
    if (n_on == '0 && tm.flags.steady_req) begin
      n_on = 4'd1;
    end
    if (n_off == '0 && tm.off_ms != '0) begin
      n_off = 4'd1;
    end

    if (tm.flags.both_zero) begin
      rsp_next = '0;
    end else begin
      rsp_next.slew_byte  = {n_rise, n_fall};
      rsp_next.pulse_byte = {n_on, n_off};
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/led_blink_timing_encoder.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  req_t: on_ms, off_ms, rise_pct, fall_pct
// rsp      out        rsp_valid / rsp_stall  rsp_t: slew_byte, pulse_byte
//
// One request per cycle while req_stall is low.
// Four register stages: saturate and multiply by percent, divide by 100 through
// a reciprocal multiply, cap the ramps, scale to counts into the output register.
// Synchronous reset clears all stage valid bits; the stage data registers are not reset.
// A stage advances whenever it is empty or the stage after it advances, so
// bubbles close up and rsp_stall reaches req_stall only when every stage is full.
`default_nettype none
module led_blink_timing_encoder (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire lbte_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output lbte_pkg::rsp_t     rsp
);
  import lbte_pkg::*;

  logic  sat_valid;
  logic  div_valid;
  logic  split_valid;
  logic  sat_adv;
  logic  div_adv;
  logic  split_adv;
  logic  count_adv;
  prod_t prod;
  time_t div_tm;
  time_t split_tm;

  // Move each stage when its slot is free or its contents move on
  assign count_adv = !rsp_valid || !rsp_stall;
  assign split_adv = !split_valid || count_adv;
  assign div_adv   = !div_valid || split_adv;
  assign sat_adv   = !sat_valid || div_adv;
  assign req_stall = !sat_adv;

  lbte_sat u_sat (
    .clk      (clk),
    .rst      (rst),
    .adv      (sat_adv),
    .valid_in (req_valid),
    .req      (req),
    .valid    (sat_valid),
    .prod     (prod)
  );

  lbte_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (div_adv),
    .valid_in (sat_valid),
    .prod     (prod),
    .valid    (div_valid),
    .tm       (div_tm)
  );

  lbte_split u_split (
    .clk      (clk),
    .rst      (rst),
    .adv      (split_adv),
    .valid_in (div_valid),
    .tm_in    (div_tm),
    .valid    (split_valid),
    .tm       (split_tm)
  );

  lbte_count u_count (
    .clk      (clk),
    .rst      (rst),
    .adv      (count_adv),
    .valid_in (split_valid),
    .tm       (split_tm),
    .valid    (rsp_valid),
    .rsp      (rsp)
  );

endmodule
`default_nettype wire
